[design/line_pixel_generator_with_clip_assert.svh]
// Assertion macros used by the line pixel generator checker.
`ifndef LINE_PIXEL_GENERATOR_WITH_CLIP_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_WITH_CLIP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line pixel generator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line pixel generator check failed");

`endif

[design/lpg_pkg.sv]
// Shared types and constants for the line pixel generator.
package lpg_pkg;

    // Frame size; pixels outside 0..size-1 are never visible.
    localparam logic [10:0] FRAME_WIDTH  = 11'd720;
    localparam logic [10:0] FRAME_HEIGHT = 11'd720;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CLIP_ON  = 2'd0;
    localparam logic [1:0] CFG_CENTER_X = 2'd1;
    localparam logic [1:0] CFG_CENTER_Y = 2'd2;
    localparam logic [1:0] CFG_RADIUS   = 2'd3;

    // Command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Reset values of the clip registers.
    localparam logic [10:0] RST_CENTER_X = 11'd360;
    localparam logic [10:0] RST_CENTER_Y = 11'd360;
    localparam logic [10:0] RST_RADIUS   = 11'd284;

    typedef struct packed {
        logic        clip_on;
        logic [10:0] mid_x;
        logic [10:0] mid_y;
        logic [10:0] radius;
    } cfg_t;

    // Pixel leaving the stepper; hide forces it invisible.
    typedef struct packed {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [23:0]        color;
        logic               done;
        logic               hide;
    } pix_t;

endpackage

[design/line_pixel_generator_with_clip.sv]
// Top level of the Bresenham line pixel generator with frame and circle clip.
//
//  channel  direction  handshake          contents
//  s_*      in         tvalid/tready      tuser command, tdata endpoints and color
//  m_*      out        tvalid/tready      tdata pixel and color, tuser visible, tlast done
//  cfg_*    in         cfg_we, no wait    clip enable, circle center and radius
//
// One transaction per cycle in and one pixel per cycle out while the output is not stalled;
// a pixel passes three registers (stepper register, square register, output register).
// The line state updates in the cycle a transaction is accepted, so steps chain freely.
// Reset clears all valid flags and the line state, and marks no line loaded.
// A stalled output holds; the two inner stages keep filling until all are full.
module line_pixel_generator_with_clip
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // start_x, start_y, end_x, end_y, line_color
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pixel_x, pixel_y, pixel_color
    output logic        m_tuser,   // pixel_visible
    output logic        m_tlast,   // line_done
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    lpg_pkg::cfg_t cfg_reg;
    lpg_pkg::pix_t pix;
    logic          pix_valid;
    logic          pix_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_on <= 1'b1;
            cfg_reg.mid_x   <= lpg_pkg::RST_CENTER_X;
            cfg_reg.mid_y   <= lpg_pkg::RST_CENTER_Y;
            cfg_reg.radius  <= lpg_pkg::RST_RADIUS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lpg_pkg::CFG_CLIP_ON:  cfg_reg.clip_on <= cfg_data[0];
                lpg_pkg::CFG_CENTER_X: cfg_reg.mid_x   <= cfg_data;
                lpg_pkg::CFG_CENTER_Y: cfg_reg.mid_y   <= cfg_data;
                lpg_pkg::CFG_RADIUS:   cfg_reg.radius  <= cfg_data;
                default:               cfg_reg         <= cfg_reg;
            endcase
        end
    end

    lpg_step u_step
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .command    (s_tuser),
        .start_x    (s_tdata[11:0]),
        .start_y    (s_tdata[23:12]),
        .end_x      (s_tdata[35:24]),
        .end_y      (s_tdata[47:36]),
        .line_color (s_tdata[71:48]),
        .pix        (pix),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready)
    );

    lpg_clip u_clip
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pix       (pix),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[design/lpg_step.sv]
// Bresenham stepper: line state and the first pixel register.
module lpg_step
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [11:0] start_x,
    input  logic signed [11:0] start_y,
    input  logic signed [11:0] end_x,
    input  logic signed [11:0] end_y,
    input  logic [23:0]        line_color,
    output lpg_pkg::pix_t      pix,
    output logic               pix_valid,
    input  logic               pix_ready
);

    logic signed [11:0] cur_x_reg, cur_x_next;
    logic signed [11:0] cur_y_reg, cur_y_next;
    logic signed [11:0] tgt_x_reg, tgt_x_next;
    logic signed [11:0] tgt_y_reg, tgt_y_next;
    logic signed [12:0] adx_reg, adx_next;
    logic signed [12:0] nady_reg, nady_next;
    logic signed [14:0] err_reg, err_next;
    logic               sxneg_reg, sxneg_next;
    logic               syneg_reg, syneg_next;
    logic               fin_reg, fin_next;
    logic [23:0]        color_reg, color_next;
    logic               valid_reg;
    lpg_pkg::pix_t      pix_reg, pix_next;

    logic               accept;
    logic signed [12:0] dx_w, dy_w;
    logic signed [15:0] twice_w;
    logic               mov_x, mov_y;

    assign in_ready  = !valid_reg || pix_ready;
    assign accept    = in_valid && in_ready;
    assign pix       = pix_reg;
    assign pix_valid = valid_reg;

    // Next line state for a load or one step
    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        tgt_x_next = tgt_x_reg;
        tgt_y_next = tgt_y_reg;
        adx_next   = adx_reg;
        nady_next  = nady_reg;
        err_next   = err_reg;
        sxneg_next = sxneg_reg;
        syneg_next = syneg_reg;
        color_next = color_reg;
        dx_w       = $signed({end_x[11], end_x}) - $signed({start_x[11], start_x});
        dy_w       = $signed({end_y[11], end_y}) - $signed({start_y[11], start_y});
        twice_w    = $signed({err_reg[14], err_reg});
        twice_w    = twice_w <<< 1;
        mov_x      = twice_w >= $signed({{3{nady_reg[12]}}, nady_reg});
        mov_y      = twice_w <= $signed({{3{adx_reg[12]}}, adx_reg});
        if (command == lpg_pkg::CMD_LOAD)
        begin
            cur_x_next = start_x;
            cur_y_next = start_y;
            tgt_x_next = end_x;
            tgt_y_next = end_y;
            color_next = line_color;
            adx_next   = dx_w[12] ? -dx_w : dx_w;
            nady_next  = dy_w[12] ? dy_w : -dy_w;
            sxneg_next = !(start_x < end_x);
            syneg_next = !(start_y < end_y);
            err_next   = $signed({{2{adx_next[12]}}, adx_next})
                       + $signed({{2{nady_next[12]}}, nady_next});
        end
        else if (!fin_reg)
        begin
            // error-term rule: x move, then y move, each from the old error
            if (mov_x)
            begin
                cur_x_next = sxneg_reg ? cur_x_reg - 12'sd1 : cur_x_reg + 12'sd1;
            end
            if (mov_y)
            begin
                cur_y_next = syneg_reg ? cur_y_reg - 12'sd1 : cur_y_reg + 12'sd1;
            end
            err_next = err_reg
                     + (mov_x ? $signed({{2{nady_reg[12]}}, nady_reg}) : 15'sd0)
                     + (mov_y ? $signed({{2{adx_reg[12]}}, adx_reg}) : 15'sd0);
        end
        fin_next       = (cur_x_next == tgt_x_next) && (cur_y_next == tgt_y_next);
        pix_next.x     = cur_x_next;
        pix_next.y     = cur_y_next;
        pix_next.color = color_next;
        pix_next.done  = fin_next;
        pix_next.hide  = (command == lpg_pkg::CMD_STEP) && fin_reg;
    end

    // Line state, updated per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            tgt_x_reg <= '0;
            tgt_y_reg <= '0;
            adx_reg   <= '0;
            nady_reg  <= '0;
            err_reg   <= '0;
            sxneg_reg <= 1'b0;
            syneg_reg <= 1'b0;
            fin_reg   <= 1'b1;
            color_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
                tgt_x_reg <= tgt_x_next;
                tgt_y_reg <= tgt_y_next;
                adx_reg   <= adx_next;
                nady_reg  <= nady_next;
                err_reg   <= err_next;
                sxneg_reg <= sxneg_next;
                syneg_reg <= syneg_next;
                fin_reg   <= fin_next;
                color_reg <= color_next;
                valid_reg <= 1'b1;
            end
            else if (pix_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Pixel register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= pix_next;
        end
    end

endmodule

[design/lpg_clip.sv]
// Pixel filter: frame test and circle test over two registered stages.
module lpg_clip
(
    input  logic               clk,
    input  logic               rst_n,
    input  lpg_pkg::cfg_t      cfg,
    input  lpg_pkg::pix_t      pix,
    input  logic               pix_valid,
    output logic               pix_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    // Square stage
    lpg_pkg::pix_t      sq_pix_reg;
    logic               sq_valid_reg;
    logic               sq_frame_reg;
    logic [23:0]        sqx_reg;
    logic [23:0]        sqy_reg;
    logic [21:0]        rsq_reg;

    // Output stage
    logic               out_valid_reg;
    logic [47:0]        out_data_reg;
    logic               out_vis_reg;
    logic               out_last_reg;

    logic               sq_ready;
    logic               out_ready;
    logic               sq_load;
    logic               out_load;
    logic signed [12:0] dxc_w, dyc_w;
    logic signed [25:0] prod_x_w, prod_y_w;
    logic [21:0]        rsq_w;
    logic               in_frame_w;
    logic [24:0]        dist_w;
    logic               vis_w;

    assign out_ready = !out_valid_reg || m_tready;
    assign sq_ready  = !sq_valid_reg || out_ready;
    assign pix_ready = sq_ready;
    assign sq_load   = pix_valid && sq_ready;
    assign out_load  = sq_valid_reg && out_ready;

    // Offsets from the circle center and their squares
    always_comb
    begin
        dxc_w      = $signed({pix.x[11], pix.x}) - $signed({2'b00, cfg.mid_x});
        dyc_w      = $signed({pix.y[11], pix.y}) - $signed({2'b00, cfg.mid_y});
        prod_x_w   = dxc_w * dxc_w;
        prod_y_w   = dyc_w * dyc_w;
        rsq_w      = cfg.radius * cfg.radius;
        in_frame_w = !pix.x[11] && (pix.x[10:0] < lpg_pkg::FRAME_WIDTH)
                  && !pix.y[11] && (pix.y[10:0] < lpg_pkg::FRAME_HEIGHT);
    end

    // Distance compare and visibility
    always_comb
    begin
        dist_w = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        vis_w  = !sq_pix_reg.hide && sq_frame_reg
              && (!cfg.clip_on || (dist_w <= {3'b000, rsq_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sq_load)
            begin
                sq_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                sq_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (sq_load)
        begin
            sq_pix_reg   <= pix;
            sq_frame_reg <= in_frame_w;
            sqx_reg      <= prod_x_w[23:0];
            sqy_reg      <= prod_y_w[23:0];
            rsq_reg      <= rsq_w;
        end
        if (out_load)
        begin
            out_data_reg <= {sq_pix_reg.color, sq_pix_reg.y, sq_pix_reg.x};
            out_vis_reg  <= vis_w;
            out_last_reg <= sq_pix_reg.done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_vis_reg;
    assign m_tlast  = out_last_reg;

endmodule

[design/lpg_check.sv]
// Port-level checker for the line pixel generator, bound to the top level.
`include "line_pixel_generator_with_clip_assert.svh"

module lpg_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result transaction holds valid and payload
    `LPG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // A visible pixel always lies inside the frame
    `LPG_ASSERT_NOW(a_vis_in_frame, m_tvalid && m_tuser, !m_tdata[11] && (m_tdata[10:0] < lpg_pkg::FRAME_WIDTH) && !m_tdata[23] && (m_tdata[22:12] < lpg_pkg::FRAME_HEIGHT))

    // When the output can move, the input is ready
    `LPG_ASSERT_NOW(a_in_ready, !m_tvalid || m_tready, s_tready)

endmodule

bind line_pixel_generator_with_clip lpg_check u_lpg_check (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for the Bresenham line pixel generator with frame and circle clip.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected pixel as it should leave the block
    typedef struct packed {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [23:0]        color;
        logic               visible;
        logic               done;
    } pixel_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;     // start_x, start_y, end_x, end_y, line_color
    logic        s_tuser = 1'b0;   // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // pixel_x, pixel_y, pixel_color
    logic        m_tuser;          // pixel_visible
    logic        m_tlast;          // line_done
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    line_pixel_generator_with_clip dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Line walker state
    int          pen_x, pen_y, goal_x, goal_y;
    int          span_x, neg_span_y, walk_err;
    bit          dir_x_neg, dir_y_neg;
    bit          walk_done = 1'b1;
    logic [23:0] pen_color = '0;

    // Clip settings
    bit clip_on = 1'b1;
    int ctr_x = int'(lpg_pkg::RST_CENTER_X);
    int ctr_y = int'(lpg_pkg::RST_CENTER_Y);
    int clip_r = int'(lpg_pkg::RST_RADIUS);

    pixel_exp_t expected_pixels[$];

    int items_sent = 0;
    int pixels_checked = 0;
    int visible_seen = 0;
    int done_seen = 0;
    int settings_used = 1;
    int mismatches = 0;
    int unexpected = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;

    // Frame filter, then the optional circle filter with an inclusive boundary
    function automatic bit pixel_shown(int px, int py);
        longint ox, oy, rr;
        if (px < 0 || px >= int'(lpg_pkg::FRAME_WIDTH) ||
            py < 0 || py >= int'(lpg_pkg::FRAME_HEIGHT))
            return 1'b0;
        if (!clip_on)
            return 1'b1;
        ox = px - ctr_x;
        oy = py - ctr_y;
        rr = clip_r;
        return (ox * ox + oy * oy) <= (rr * rr);
    endfunction

    // Advance the walker by one transaction and return the pixel it produces
    function automatic pixel_exp_t predict_pixel(logic cmd, logic signed [11:0] sx,
                                                 logic signed [11:0] sy,
                                                 logic signed [11:0] ex,
                                                 logic signed [11:0] ey,
                                                 logic [23:0] col);
        pixel_exp_t p;
        int dx, dy, twice;
        bit shown;
        if (cmd == lpg_pkg::CMD_LOAD)
        begin
            pen_x = sx;
            pen_y = sy;
            goal_x = ex;
            goal_y = ey;
            pen_color = col;
            dx = goal_x - pen_x;
            dy = goal_y - pen_y;
            span_x = (dx < 0) ? -dx : dx;
            neg_span_y = (dy < 0) ? dy : -dy;
            dir_x_neg = !(pen_x < goal_x);
            dir_y_neg = !(pen_y < goal_y);
            walk_err = span_x + neg_span_y;
            walk_done = (pen_x == goal_x) && (pen_y == goal_y);
            shown = pixel_shown(pen_x, pen_y);
        end
        else if (walk_done)
        begin
            // stepping past the end repeats the end point, hidden
            shown = 1'b0;
        end
        else
        begin
            twice = 2 * walk_err;
            if (twice >= neg_span_y)
            begin
                walk_err += neg_span_y;
                pen_x += dir_x_neg ? -1 : 1;
            end
            if (twice <= span_x)
            begin
                walk_err += span_x;
                pen_y += dir_y_neg ? -1 : 1;
            end
            walk_done = (pen_x == goal_x) && (pen_y == goal_y);
            shown = pixel_shown(pen_x, pen_y);
        end
        p.x = pen_x[11:0];
        p.y = pen_y[11:0];
        p.color = pen_color;
        p.visible = shown;
        p.done = walk_done;
        return p;
    endfunction

    // Send one command transaction; bursts of random length, separated by random gaps when gaps_on is set
    task automatic send_item(logic cmd, logic signed [11:0] sx, logic signed [11:0] sy,
                             logic signed [11:0] ex, logic signed [11:0] ey,
                             logic [23:0] col);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {col, ey, ex, sy, sx};
        do
            @(posedge clk);
        while (!s_tready);
        expected_pixels.push_back(predict_pixel(cmd, sx, sy, ex, ey, col));
        items_sent++;
    endtask

    // Step with a random payload, which the block must ignore
    task automatic send_step();
        send_item(lpg_pkg::CMD_STEP, 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom), 24'($urandom));
    endtask

    // Load a line, walk up to step_cap pixels, then send extra_steps more steps
    task automatic walk_line(logic signed [11:0] sx, logic signed [11:0] sy,
                             logic signed [11:0] ex, logic signed [11:0] ey,
                             logic [23:0] col, int step_cap, int extra_steps);
        int n;
        send_item(lpg_pkg::CMD_LOAD, sx, sy, ex, ey, col);
        n = 0;
        while (!walk_done && n < step_cap)
        begin
            send_step();
            n++;
        end
        repeat (extra_steps) send_step();
    endtask

    // Stop sending and let every pending pixel come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Rewrite all four clip registers while the block is idle
    task automatic set_clip(bit on, int cx, int cy, int r);
        logic [10:0] vals[4];
        logic [1:0]  idx[4];
        vals = '{11'(on), 11'(cx), 11'(cy), 11'(r)};
        idx = '{lpg_pkg::CFG_CLIP_ON, lpg_pkg::CFG_CENTER_X, lpg_pkg::CFG_CENTER_Y,
                lpg_pkg::CFG_RADIUS};
        wait_idle();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        clip_on = on;
        ctr_x = vals[1];
        ctr_y = vals[2];
        clip_r = vals[3];
        settings_used++;
        @(posedge clk);
    endtask

    // Steps with no line loaded sit at the origin, hidden and done
    task automatic test_step_without_line();
        repeat (3) send_step();
    endtask

    // Circle boundary, degenerate line, extreme endpoints and all octants
    task automatic test_directed_lines();
        int oct_dx[8];
        int oct_dy[8];
        oct_dx = '{3, 1, -1, -3, -3, -1, 1, 3};
        oct_dy = '{1, 3, 3, 1, -1, -3, -3, -1};
        // on the circle edge, one past it, then done
        walk_line(12'sd644, 12'sd360, 12'sd646, 12'sd360, 24'hFFFFFF, 10, 0);
        walk_line(12'sd5, 12'sd5, 12'sd5, 12'sd5, 24'h000000, 10, 1);
        walk_line(-12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048, 24'hA5A5A5, 2, 0);
        for (int i = 0; i < 8; i++)
            walk_line(12'sd360, 12'sd360, 12'(360 + oct_dx[i]), 12'(360 + oct_dy[i]),
                      24'h5A5A5A ^ 24'(i), 1, 0);
    endtask

    // Frame edges with the circle filter off
    task automatic test_frame_edges();
        set_clip(1'b0, 0, 0, 0);
        walk_line(12'sd718, -12'sd1, 12'sd721, 12'sd2, 24'h123456, 10, 1);
        walk_line(-12'sd1, 12'sd718, 12'sd1, 12'sd720, 24'hEDCBA9, 10, 1);
    endtask

    // Mostly complete lines around the frame, some cut short, some noise;
    // the call starts no new walk once its item budget is used
    task automatic random_lines(int count);
        int goal_items, kind, span, dx, dy;
        logic signed [11:0] sx, sy;
        goal_items = items_sent + count;
        while (items_sent < goal_items)
        begin
            kind = $urandom_range(0, 9);
            sx = 12'($urandom_range(0, 800) - 40);
            sy = 12'($urandom_range(0, 800) - 40);
            span = ($urandom_range(0, 7) == 0) ? 200 : 24;
            dx = $urandom_range(0, 2 * span) - span;
            dy = $urandom_range(0, 2 * span) - span;
            case (kind)
                0: walk_line(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                             24'($urandom), $urandom_range(0, 3), 0);
                1: walk_line(sx, sy, 12'(sx + dx), 12'(sy + dy), 24'($urandom),
                             $urandom_range(0, 5), 0);
                2: repeat ($urandom_range(1, 3)) send_step();
                default: walk_line(sx, sy, 12'(sx + dx), 12'(sy + dy), 24'($urandom),
                                   goal_items - items_sent, $urandom_range(0, 2));
            endcase
        end
    endtask

    // Random traffic under several clip settings, extremes included
    task automatic test_clip_settings();
        gaps_on = 1'b0;
        random_lines(60);
        gaps_on = 1'b1;
        random_lines(60);
        set_clip(1'b1, 0, 0, 0);
        random_lines(70);
        set_clip(1'b1, 2047, 2047, 2047);
        random_lines(90);
        set_clip(1'b1, $urandom_range(200, 520), $urandom_range(200, 520),
                 $urandom_range(100, 400));
        random_lines(90);
        set_clip(1'b1, int'(lpg_pkg::RST_CENTER_X), int'(lpg_pkg::RST_CENTER_Y),
                 int'(lpg_pkg::RST_RADIUS));
        random_lines(50);
    endtask

    // Receiver: stall modes chosen at random, each held until stall_count runs out
    int stall_mode = 0;
    int stall_count = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_mode <= 0;
            stall_count <= 0;
        end
        else
        begin
            if (stall_count == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_count <= $urandom_range(20, 120);
            end
            else
                stall_count <= stall_count - 1;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (stall_count[1:0] == 2'd0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Compare each output transaction with the oldest expected pixel
    always @(posedge clk)
    begin
        pixel_exp_t want, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x = m_tdata[11:0];
            got.y = m_tdata[23:12];
            got.color = m_tdata[47:24];
            got.visible = m_tuser;
            got.done = m_tlast;
            if (expected_pixels.size() == 0)
            begin
                unexpected++;
                if (unexpected + mismatches <= 10)
                    $display("ERROR: unexpected pixel x=%0d y=%0d color=%06h vis=%0b done=%0b",
                             got.x, got.y, got.color, got.visible, got.done);
            end
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                visible_seen += got.visible;
                done_seen += got.done;
                if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
                    got.visible !== want.visible || got.done !== want.done)
                begin
                    mismatches++;
                    if (unexpected + mismatches <= 10)
                        $display({"ERROR: pixel %0d expected x=%0d y=%0d color=%06h ",
                                  "vis=%0b done=%0b, got x=%0d y=%0d color=%06h vis=%0b ",
                                  "done=%0b"},
                                 pixels_checked, want.x, want.y, want.color, want.visible,
                                 want.done, got.x, got.y, got.color, got.visible, got.done);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_step_without_line();
        test_directed_lines();
        test_frame_edges();
        test_clip_settings();
        wait_idle();
        repeat (10) @(posedge clk);
        $display("tb: %0d input transactions, %0d pixels checked (%0d visible, %0d done)",
                 items_sent, pixels_checked, visible_seen, done_seen);
        $display("tb: %0d clip settings incl. clip off, zero radius and far corner center",
                 settings_used);
        if (mismatches == 0 && unexpected == 0 && expected_pixels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("tb: timeout with %0d pixels outstanding", expected_pixels.size());
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/lpg_pkg.sv
design/lpg_step.sv
design/lpg_clip.sv
design/line_pixel_generator_with_clip.sv
design/lpg_check.sv
tb/sv/tb_top.sv
